FILE: rtl/twdt_pkg.sv
// Shared types and constants for the tuning word to decimal text block.
`default_nettype none

package twdt_pkg;

    localparam int CPH_BITS  = 24;
    localparam int FREQ_BITS = 27;
    localparam int DIGITS    = 8;
    localparam int BCD_BITS  = DIGITS * 4;
    localparam int CHAR_BITS = 7;

    localparam logic [CPH_BITS-1:0]  CPH_RESET = 24'd1407375;
    localparam logic [FREQ_BITS-1:0] FREQ_MAX  = 27'd99999999;
    localparam logic [CHAR_BITS-1:0] CH_ZERO   = 7'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE   = 7'h39;
    localparam logic [CHAR_BITS-1:0] CH_DOT    = 7'h2E;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } unit_state_t;

    typedef struct packed {
        logic [FREQ_BITS-1:0] freq;
        logic                 panel;
        logic                 ovf;
    } freq_rec_t;

    typedef struct packed {
        logic [BCD_BITS-1:0] digits;
        logic                panel;
        logic                ovf;
    } digit_rec_t;

endpackage

`default_nettype wire

FILE: rtl/tuning_word_to_decimal_text_top.sv
// Top level of the tuning word to decimal text converter.
//
// Each tuning word accepted on the slave side is divided by counts_per_hz and
// comes out as eight decimal ASCII characters (or nine/ten with panel dots),
// one word per cycle while m_tready is high, with tlast on the final
// character and tuser set on every word of a saturated item. The divider
// retires six quotient bits per cycle. The divider, the BCD converter and
// the emitter each take a new item only as they pass on the last one, so
// they work on different items at once. A two-entry queue sits between the
// converter and the emitter.
// counts_per_hz may be written only while idle.
`default_nettype none

module tuning_word_to_decimal_text_top #(
    parameter int WORD_BITS = 48
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [((WORD_BITS+7)/8)*8-1:0]   s_tdata,   // tuning_word
    input  wire                              s_tuser,   // panel_format
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [7:0]                       m_tdata,   // char_code
    output logic                             m_tlast,   // last_char
    output logic                             m_tuser,   // overflow
    input  wire                              cfg_we,
    input  wire  [twdt_pkg::CPH_BITS-1:0]    cfg_wdata  // counts_per_hz
);
    import twdt_pkg::*;

    logic [CPH_BITS-1:0] cph_reg;
    logic [CPH_BITS-1:0] cph_next;

    logic       div_valid, div_ready;
    freq_rec_t  div_rec;
    logic       bcd_valid, bcd_ready;
    digit_rec_t bcd_rec;
    logic       q_valid, q_ready;
    digit_rec_t q_rec;

    assign cph_next = cfg_we ? cfg_wdata : cph_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cph_reg <= CPH_RESET;
        end
        else
        begin
            cph_reg <= cph_next;
        end
    end

    twdt_div #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (s_tdata[WORD_BITS-1:0]),
        .in_panel  (s_tuser),
        .cph       (cph_reg),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_rec   (div_rec)
    );

    twdt_bcd u_bcd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_rec    (div_rec),
        .out_valid (bcd_valid),
        .out_ready (bcd_ready),
        .out_rec   (bcd_rec)
    );

    twdt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bcd_valid),
        .in_ready  (bcd_ready),
        .in_rec    (bcd_rec),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_rec   (q_rec)
    );

    twdt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (q_valid),
        .rec_ready (q_ready),
        .rec_in    (q_rec),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

FILE: rtl/twdt_div.sv
// Iterative restoring divider: tuning word over counts per hertz, with saturation.
`default_nettype none

module twdt_div #(
    parameter int WORD_BITS = 48
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  [WORD_BITS-1:0]           in_word,
    input  wire                            in_panel,
    input  wire  [twdt_pkg::CPH_BITS-1:0]  cph,
    output logic                           out_valid,
    input  wire                            out_ready,
    output twdt_pkg::freq_rec_t            out_rec
);
    import twdt_pkg::*;

    localparam int RADIX = 6;
    localparam int STEPS = (WORD_BITS + RADIX - 1) / RADIX;
    localparam int QW    = STEPS * RADIX;
    localparam int CNT_W = $clog2(STEPS);

    unit_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [QW-1:0]       quo_reg, quo_next;
    logic [CPH_BITS-1:0] rem_reg, rem_next;
    logic                panel_reg, panel_next;
    logic                zdiv_reg, zdiv_next;

    logic [QW-1:0]       step_quo;
    logic [CPH_BITS-1:0] step_rem;
    logic                accept;
    logic                ovf;

    always_comb
    begin
        logic [QW-1:0]       q;
        logic [CPH_BITS-1:0] r;
        logic [CPH_BITS:0]   t;
        q = quo_reg;
        r = rem_reg;
        for (int i = 0; i < RADIX; i++)
        begin
            t = {r, q[QW-1]};
            q = {q[QW-2:0], 1'b0};
            if (t >= {1'b0, cph})
            begin
                t    = t - {1'b0, cph};
                q[0] = 1'b1;
            end
            r = t[CPH_BITS-1:0];
        end
        step_quo = q;
        step_rem = r;
    end

    assign in_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == ST_DONE);

    assign ovf          = zdiv_reg || (quo_reg > QW'(FREQ_MAX));
    assign out_rec.freq = ovf ? FREQ_MAX : quo_reg[FREQ_BITS-1:0];
    assign out_rec.panel = panel_reg;
    assign out_rec.ovf   = ovf;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        panel_next = panel_reg;
        zdiv_next  = zdiv_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                quo_next = step_quo;
                rem_next = step_rem;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = accept ? ST_RUN : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (accept)
        begin
            cnt_next   = CNT_W'(STEPS - 1);
            quo_next   = QW'(in_word);
            rem_next   = '0;
            panel_next = in_panel;
            zdiv_next  = (cph == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        panel_reg <= panel_next;
        zdiv_reg  <= zdiv_next;
    end

endmodule

`default_nettype wire

FILE: rtl/twdt_bcd.sv
// Iterative double-dabble binary to BCD converter, four shifts per cycle.
`default_nettype none

module twdt_bcd (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  twdt_pkg::freq_rec_t   in_rec,
    output logic                  out_valid,
    input  wire                   out_ready,
    output twdt_pkg::digit_rec_t  out_rec
);
    import twdt_pkg::*;

    localparam int SHIFTS = 4;
    localparam int BSTEPS = (FREQ_BITS + SHIFTS - 1) / SHIFTS;
    localparam int BIN_W  = BSTEPS * SHIFTS;
    localparam int CNT_W  = $clog2(BSTEPS);

    unit_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [BIN_W-1:0]    bin_reg, bin_next;
    logic [BCD_BITS-1:0] bcd_reg, bcd_next;
    logic                panel_reg, panel_next;
    logic                ovf_reg, ovf_next;

    logic [BIN_W-1:0]    step_bin;
    logic [BCD_BITS-1:0] step_bcd;
    logic                accept;

    always_comb
    begin
        logic [BIN_W-1:0]    b;
        logic [BCD_BITS-1:0] d;
        b = bin_reg;
        d = bcd_reg;
        for (int s = 0; s < SHIFTS; s++)
        begin
            for (int n = 0; n < DIGITS; n++)
            begin
                if (d[n*4 +: 4] >= 4'd5)
                begin
                    d[n*4 +: 4] = d[n*4 +: 4] + 4'd3;
                end
            end
            d = {d[BCD_BITS-2:0], b[BIN_W-1]};
            b = {b[BIN_W-2:0], 1'b0};
        end
        step_bin = b;
        step_bcd = d;
    end

    assign in_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == ST_DONE);

    assign out_rec.digits = bcd_reg;
    assign out_rec.panel  = panel_reg;
    assign out_rec.ovf    = ovf_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        panel_next = panel_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                bin_next = step_bin;
                bcd_next = step_bcd;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = accept ? ST_RUN : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (accept)
        begin
            cnt_next   = CNT_W'(BSTEPS - 1);
            bin_next   = BIN_W'(in_rec.freq);
            bcd_next   = '0;
            panel_next = in_rec.panel;
            ovf_next   = in_rec.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        panel_reg <= panel_next;
        ovf_reg   <= ovf_next;
    end

endmodule

`default_nettype wire

FILE: rtl/twdt_fifo.sv
// Two-entry queue of digit records between the converter and the character emitter.
`default_nettype none

module twdt_fifo (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  twdt_pkg::digit_rec_t  in_rec,
    output logic                  out_valid,
    input  wire                   out_ready,
    output twdt_pkg::digit_rec_t  out_rec
);
    import twdt_pkg::*;

    digit_rec_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_rec   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_rec;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/twdt_back.sv
// Emitter: walks digit records, one ASCII word per cycle; m_tready stalls it.
`default_nettype none

module twdt_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   rec_valid,
    output logic                  rec_ready,
    input  twdt_pkg::digit_rec_t  rec_in,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);
    import twdt_pkg::*;

    localparam logic [3:0] SLOT_DOT_A      = 4'd2;
    localparam logic [3:0] SLOT_DOT_B      = 4'd6;
    localparam logic [3:0] SLOT_LAST_PANEL = 4'd9;
    localparam logic [3:0] SLOT_LAST_PLAIN = 4'd7;

    digit_rec_t     rec_reg, rec_next;
    logic [3:0]     slot_reg, slot_next;
    logic           active_reg, active_next;
    logic           valid_reg, valid_next;
    logic [CHAR_BITS-1:0] char_reg, char_next;
    logic           last_reg, last_next;
    logic           ovf_reg, ovf_next;

    logic [3:0]     dig_slot;
    logic [2:0]     dig_idx;
    logic [3:0]     dig_val;
    logic           is_dot;
    logic           is_last;
    logic           emit;
    logic           load;

    always_comb
    begin
        if (!rec_reg.panel || (slot_reg < SLOT_DOT_A))
        begin
            dig_slot = slot_reg;
        end
        else if (slot_reg < SLOT_DOT_B)
        begin
            dig_slot = slot_reg - 4'd1;
        end
        else
        begin
            dig_slot = slot_reg - 4'd2;
        end
        dig_idx = dig_slot[2:0];
        dig_val = rec_reg.digits[(DIGITS - 1 - int'(dig_idx)) * 4 +: 4];
        is_dot  = rec_reg.panel && ((slot_reg == SLOT_DOT_A) || (slot_reg == SLOT_DOT_B));
        is_last = rec_reg.panel ? (slot_reg == SLOT_LAST_PANEL) : (slot_reg == SLOT_LAST_PLAIN);
    end

    assign emit      = active_reg && (!valid_reg || m_tready);
    assign rec_ready = !active_reg || (emit && is_last);
    assign load      = rec_valid && rec_ready;

    always_comb
    begin
        rec_next    = rec_reg;
        slot_next   = slot_reg;
        active_next = active_reg;
        valid_next  = valid_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        ovf_next    = ovf_reg;
        if (valid_reg && m_tready)
        begin
            valid_next = 1'b0;
        end
        if (emit)
        begin
            valid_next = 1'b1;
            char_next  = is_dot ? CH_DOT : (CH_ZERO + {3'b000, dig_val});
            last_next  = is_last;
            ovf_next   = rec_reg.ovf;
            slot_next  = slot_reg + 4'd1;
            if (is_last)
            begin
                active_next = 1'b0;
            end
        end
        if (load)
        begin
            rec_next    = rec_in;
            active_next = 1'b1;
            slot_next   = (rec_in.panel && (rec_in.digits[BCD_BITS-1 -: 4] == 4'd0))
                          ? 4'd1 : 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg  <= rec_next;
        slot_reg <= slot_next;
        char_reg <= char_next;
        last_reg <= last_next;
        ovf_reg  <= ovf_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = ovf_reg;

endmodule

`default_nettype wire

FILE: rtl/twdt_chk.sv
// Port-level checker for the converter output stream, bound to the top level.
`default_nettype none

module twdt_chk (
    input wire       clk,
    input wire       rst_n,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata,
    input wire       m_tlast,
    input wire       m_tuser
);
    import twdt_pkg::*;

    logic is_digit;
    logic is_dot;

    assign is_digit = (m_tdata[7] == 1'b0) && (m_tdata[6:0] >= CH_ZERO) &&
                      (m_tdata[6:0] <= CH_NINE);
    assign is_dot   = (m_tdata == {1'b0, CH_DOT});

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("output word changed while stalled");

    a_charset: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> is_digit || is_dot)
        else $error("output word is neither digit nor dot");

    a_dot_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && is_dot |-> !m_tlast)
        else $error("dot closes a text");

    a_sat_nines: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> is_dot || (m_tdata == {1'b0, CH_NINE}))
        else $error("saturated text holds a digit other than nine");

endmodule

bind tuning_word_to_decimal_text_top twdt_chk u_twdt_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
